/* src/assert_macros.svh */
// Shared assertion helpers; clock and reset are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define SST_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define SST_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sst_pkg.sv */
package sst_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 6;
  localparam int POS_W        = 7;
  localparam int CNT_W        = 7;
  localparam int TYPE_W       = 2;
  localparam int STAT_W       = 3;
  localparam int IN_DATA_W    = 40;  // value + read_index, padded to bytes
  localparam int OUT_DATA_W   = 48;  // position + entry_value + entry_count, padded

  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ_OK   = 3'd5;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_EXEC
  } fsm_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

/* src/sst_cell.sv */
module sst_cell
  import sst_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic              valid,       // this slot is below the fill count
  input  logic              left_lt,
  input  logic [DATA_W-1:0] left_entry,
  input  logic [DATA_W-1:0] right_entry,
  output logic [DATA_W-1:0] entry,
  output logic              lt,
  output logic              eq
);

  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic              lt_r, lt_nxt;
  logic              eq_r, eq_nxt;

  always_comb begin
    entry_nxt = entry_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    unique case (cmd.op)
      CELL_CMP: begin
        lt_nxt = valid && ($signed(entry_r) < $signed(cmd.value));
        eq_nxt = valid && (entry_r == cmd.value);
      end
      // Slots below the insertion point keep; the first slot at or above it
      // takes the new value, everything past it shifts one to the right.
      CELL_INS: begin
        if (!lt_r) begin
          entry_nxt = left_lt ? cmd.value : left_entry;
        end
      end
      // Slots at or above the match pull from the right neighbor.
      CELL_DEL: begin
        if (!lt_r) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    lt_r    <= lt_nxt;
    eq_r    <= eq_nxt;
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

/* src/sst_reduce.sv */
module sst_reduce
  import sst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int PW       = $clog2(CAPACITY + 1)
) (
  input  logic [DATA_W-1:0]   ent [CAPACITY],
  input  logic [CAPACITY-1:0] lt,
  input  logic [CAPACITY-1:0] eq,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic                found,
  output logic [PW-1:0]       pos,
  output logic [DATA_W-1:0]   rd_data
);

  logic [CAPACITY-1:0] lt_left;
  logic [CAPACITY-1:0] boundary;

  // Entries are sorted, so lt is a run of ones from slot 0; the first zero
  // is the lower bound.
  assign lt_left  = {lt[CAPACITY-2:0], 1'b1};
  assign boundary = lt_left & ~lt;

  always_comb begin
    found   = 1'b0;
    pos     = '0;
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | eq[i];
      if (boundary[i]) begin
        pos = pos | PW'(i);
      end
      if (32'(rd_idx) == i) begin
        rd_data = rd_data | ent[i];
      end
    end
  end

endmodule

/* src/sorted_set_table_core.sv */
// Sorted set table: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of cells, one value per cell. Each request
// (insert, delete, read by position) returns exactly one result with status,
// position, value and the entry count after the operation. A request is
// accepted in idle; in compare every cell compares its value against the
// request; in apply the cells shift toward or away from the affected position
// on a successful insert or delete, and the result is registered. The next
// request is accepted only after the state returns to idle, so a new request
// is never taken while an earlier one is in flight. The apply step waits only
// while an earlier result still sits unread in the output register. No
// clearing pass runs after reset; slots above the count are never observed.
module sorted_set_table_core
  import sst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // value[31:0], read_index[37:32]
  input  logic [TYPE_W-1:0]     in_tuser,   // req_type[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // position[6:0], entry_value[38:7],
                                            // entry_count[45:39]
  output logic [STAT_W-1:0]     out_tuser   // status[2:0]
);

  localparam int CW = $clog2(CAPACITY + 1);

  fsm_t state_r, state_nxt;

  logic [TYPE_W-1:0] req_type_r;
  logic [DATA_W-1:0] req_value_r;
  logic [IDX_W-1:0]  req_idx_r;

  logic [CW-1:0] count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic in_fire, exec_go, out_free;
  cell_cmd_t cmd;
  cell_op_t  exec_op;

  logic [DATA_W-1:0]   ent [CAPACITY];
  logic [CAPACITY-1:0] lt, eq, valid;
  logic                found;
  logic [CW-1:0]       pos;
  logic [DATA_W-1:0]   rd_data;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // ---------------- cell row ----------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic              l_lt;
    logic [DATA_W-1:0] l_ent, r_ent;

    assign valid[g] = CW'(g) < count_r;

    if (g == 0) begin : g_first
      assign l_lt  = 1'b1;
      assign l_ent = '0;
    end else begin : g_mid
      assign l_lt  = lt[g-1];
      assign l_ent = ent[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign r_ent = ent[g];
    end else begin : g_inner
      assign r_ent = ent[g+1];
    end

    sst_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .valid       (valid[g]),
      .left_lt     (l_lt),
      .left_entry  (l_ent),
      .right_entry (r_ent),
      .entry       (ent[g]),
      .lt          (lt[g]),
      .eq          (eq[g])
    );
  end

  sst_reduce #(
    .CAPACITY (CAPACITY),
    .PW       (CW)
  ) u_reduce (
    .ent     (ent),
    .lt      (lt),
    .eq      (eq),
    .rd_idx  (req_idx_r),
    .found   (found),
    .pos     (pos),
    .rd_data (rd_data)
  );

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_fire) state_nxt = FSM_CMP;
      FSM_CMP:  state_nxt = FSM_EXEC;
      FSM_EXEC: if (out_free) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    exec_go   = 1'b0;
    cmd.op    = CELL_HOLD;
    cmd.value = req_value_r;
    unique case (state_r)
      FSM_IDLE: in_tready = 1'b1;
      FSM_CMP:  cmd.op = CELL_CMP;
      FSM_EXEC: begin
        exec_go = out_free;
        if (out_free) begin
          cmd.op = exec_op;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- result decision ----------------
  always_comb begin
    exec_op        = CELL_HOLD;
    count_nxt      = count_r;
    out_status_nxt = ST_NOT_FOUND;
    out_pos_nxt    = POS_W'(CAPACITY);
    out_val_nxt    = '0;
    unique case (req_type_r)
      REQ_INSERT: begin
        out_val_nxt = req_value_r;
        if (found) begin
          out_status_nxt = ST_DUPLICATE;
          out_pos_nxt    = POS_W'(pos);
        end else if (count_r == CW'(CAPACITY)) begin
          out_status_nxt = ST_FULL;
        end else begin
          exec_op        = CELL_INS;
          count_nxt      = CW'(count_r + 1'b1);
          out_status_nxt = ST_INSERTED;
          out_pos_nxt    = POS_W'(pos);
        end
      end
      REQ_DELETE: begin
        out_val_nxt = req_value_r;
        if (found) begin
          exec_op        = CELL_DEL;
          count_nxt      = CW'(count_r - 1'b1);
          out_status_nxt = ST_DELETED;
          out_pos_nxt    = POS_W'(pos);
        end
      end
      REQ_READ: begin
        if (32'(req_idx_r) < 32'(count_r)) begin
          out_status_nxt = ST_READ_OK;
          out_pos_nxt    = POS_W'(req_idx_r);
          out_val_nxt    = rd_data;
        end
      end
      default: begin
      end
    endcase
    out_cnt_nxt = CNT_W'(count_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r  <= in_tuser;
      req_value_r <= in_tdata[DATA_W-1:0];
      req_idx_r   <= in_tdata[DATA_W+IDX_W-1:DATA_W];
    end
    if (exec_go) begin
      out_status_r <= out_status_nxt;
      out_pos_r    <= out_pos_nxt;
      out_val_r    <= out_val_nxt;
      out_cnt_r    <= out_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_val_r, out_pos_r};

endmodule

/* src/sst_checker.sv */
`include "assert_macros.svh"

module sst_checker
  import sst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser
);

  localparam logic [POS_W-1:0] NONE_POS = POS_W'(CAPACITY);

  logic                         out_stall;
  logic                         req_taken;
  logic                         rejected;
  logic [STAT_W+OUT_DATA_W-1:0] out_word;

  assign out_stall = out_tvalid && !out_tready;
  assign req_taken = in_tvalid && in_tready;
  assign rejected  = out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_NOT_FOUND);
  assign out_word  = {out_tuser, out_tdata};

  // Held result must not change until taken.
  `SST_CHECK_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "held result changed")

  // One request at a time: no acceptance right after an acceptance.
  `SST_CHECK_NEXT(a_busy_after_req, req_taken, !in_tready, "request accepted while busy")

  `SST_CHECK(a_status_legal, out_tvalid, out_tuser <= ST_READ_OK, "illegal status code")

  `SST_CHECK(a_full_no_pos, rejected, out_tdata[POS_W-1:0] == NONE_POS, "no position expected")

endmodule

bind sorted_set_table_core sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (.*);

/* sim/tb_sorted_set_table_core.sv */
module tb_sorted_set_table_core;
  import sst_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [POS_W-1:0]  POS_NONE   = POS_W'(CAPACITY_DEF);
  localparam int                MAX_REPORTS = 10;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_value;
    logic [CNT_W-1:0]  entry_count;
  } table_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [TYPE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  // shadow copy of the sorted table, ascending
  logic signed [DATA_W-1:0] shadow_vals[$];
  table_result_t            pending_results[$];
  int                       bad_results = 0;
  int                       send_idle_pct = 0;
  int                       recv_idle_pct = 0;
  int                       hold_cycles_req = 0;
  int                       hold_reqs = 0;
  int                       hold_seen = 0;
  int                       hold_left = 0;
  bit                       grow_table = 1'b1;

  sorted_set_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("FAIL sorted_set_table_core");
    $finish;
  end

  // first index whose entry is not below v
  function automatic int lower_bound(logic signed [DATA_W-1:0] v);
    int i;
    i = 0;
    while (i < shadow_vals.size() && shadow_vals[i] < v) i++;
    return i;
  endfunction

  function automatic table_result_t apply_request(logic [TYPE_W-1:0] kind,
                                                  logic signed [DATA_W-1:0] val,
                                                  logic [IDX_W-1:0] idx);
    table_result_t r;
    int            p;
    r.status      = ST_NOT_FOUND;
    r.position    = POS_NONE;
    r.entry_value = val;
    case (kind)
      REQ_INSERT: begin
        p = lower_bound(val);
        if (p < shadow_vals.size() && shadow_vals[p] == val) begin
          r.status   = ST_DUPLICATE;
          r.position = POS_W'(p);
        end else if (shadow_vals.size() >= CAPACITY_DEF) begin
          r.status = ST_FULL;
        end else begin
          shadow_vals.insert(p, val);
          r.status   = ST_INSERTED;
          r.position = POS_W'(p);
        end
      end
      REQ_DELETE: begin
        p = lower_bound(val);
        if (p < shadow_vals.size() && shadow_vals[p] == val) begin
          shadow_vals.delete(p);
          r.status   = ST_DELETED;
          r.position = POS_W'(p);
        end
      end
      REQ_READ: begin
        if (idx < shadow_vals.size()) begin
          r.status      = ST_READ_OK;
          r.position    = POS_W'(idx);
          r.entry_value = shadow_vals[idx];
        end else begin
          r.entry_value = '0;
        end
      end
      default: r.entry_value = '0;
    endcase
    r.entry_count = CNT_W'(shadow_vals.size());
    return r;
  endfunction

  task automatic send_request(logic [TYPE_W-1:0] kind, logic signed [DATA_W-1:0] val,
                              logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, idx, val};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(kind, val, idx));
  endtask

  // result checker
  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[6:0], out_tdata[38:7], out_tdata[45:39]};
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected result: status %0d pos %0d value %0d count %0d",
                   got.status, got.position, $signed(got.entry_value), got.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("mismatch: exp status %0d pos %0d value %0d count %0d,",
                     want.status, want.position, $signed(want.entry_value),
                     want.entry_count,
                     " got status %0d pos %0d value %0d count %0d",
                     got.status, got.position,
                     $signed(got.entry_value), got.entry_count);
        end
      end
    end
  end

  // result-side ready, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_left = hold_cycles_req;
      hold_seen = hold_reqs;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 70) return int'($urandom_range(120)) - 60;
    if (r < 82) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7fff_ffff;
        3: return 32'sh7fff_fffe;
        4: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic test_directed();
    send_request(REQ_READ, 0, 6'd0);           // read on empty
    send_request(REQ_READ, 0, 6'd63);
    send_request(REQ_DELETE, 5, 6'd0);         // delete on empty
    send_request(REQ_UNUSED, 32'sh5a5a_a5a5, 6'd63);
    send_request(REQ_INSERT, 32'sh7fff_ffff, 6'd0);
    send_request(REQ_INSERT, 32'sh8000_0000, 6'd0);
    send_request(REQ_INSERT, 0, 6'd0);
    send_request(REQ_INSERT, -1, 6'd0);
    send_request(REQ_INSERT, 1, 6'd0);
    send_request(REQ_INSERT, 32'sh8000_0000, 6'd0);  // duplicate at head
    send_request(REQ_INSERT, 32'sh7fff_ffff, 6'd0);  // duplicate at tail
    send_request(REQ_READ, 0, 6'd0);
    send_request(REQ_READ, 0, 6'd2);
    send_request(REQ_READ, 0, 6'd4);
    send_request(REQ_READ, 32'sh1234_5678, 6'd5);    // just past the count
    send_request(REQ_DELETE, 0, 6'd0);
    send_request(REQ_DELETE, 7, 6'd0);               // absent
    send_request(REQ_DELETE, 32'sh8000_0000, 6'd0);
    send_request(REQ_DELETE, 32'sh7fff_ffff, 6'd0);
    send_request(REQ_READ, 0, 6'd1);
    send_request(REQ_UNUSED, 0, 6'd0);
  endtask

  task automatic test_fill_to_full();
    int               k;
    logic signed [DATA_W-1:0] v;
    k = 0;
    while (shadow_vals.size() < CAPACITY_DEF) begin
      send_request(REQ_INSERT, -3000 + 97 * k, 6'($urandom));
      k++;
    end
    send_request(REQ_INSERT, 32'sh4000_0000, 6'd0);  // full
    send_request(REQ_INSERT, shadow_vals[10], 6'd0);  // duplicate wins over full
    send_request(REQ_READ, 0, 6'd63);
    send_request(REQ_READ, 0, 6'd0);
    v = shadow_vals[CAPACITY_DEF - 1];
    send_request(REQ_DELETE, v, 6'd0);
    send_request(REQ_INSERT, v, 6'd0);
    grow_table = 1'b0;
  endtask

  task automatic test_random_traffic(int n);
    int                       r;
    int                       ins_pct;
    logic signed [DATA_W-1:0] v;
    logic [IDX_W-1:0]         idx;
    repeat (n) begin
      if (shadow_vals.size() >= CAPACITY_DEF) grow_table = 1'b0;
      else if (shadow_vals.size() == 0) grow_table = 1'b1;
      else if ($urandom_range(99) < 2) grow_table = !grow_table;
      ins_pct = grow_table ? 70 : 30;
      r = $urandom_range(99);
      if ($urandom_range(1) == 0 || shadow_vals.size() == 0)
        idx = IDX_W'($urandom_range(63));
      else
        idx = IDX_W'($urandom_range(shadow_vals.size() - 1));
      if (r < 4) begin
        send_request(REQ_UNUSED, $urandom, IDX_W'($urandom_range(63)));
      end else if (r < 16) begin
        send_request(REQ_READ, $urandom, idx);
      end else if ($urandom_range(99) < ins_pct) begin
        send_request(REQ_INSERT, pick_value(), IDX_W'($urandom_range(63)));
      end else begin
        if (shadow_vals.size() != 0 && $urandom_range(99) < 60)
          v = shadow_vals[$urandom_range(shadow_vals.size() - 1)];
        else
          v = pick_value();
        send_request(REQ_DELETE, v, IDX_W'($urandom_range(63)));
      end
    end
  endtask

  // output held off long enough that the table stalls its input
  task automatic test_output_backpressure();
    hold_cycles_req = 400;
    hold_reqs++;
    test_random_traffic(40);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 83;
    test_directed();
    test_fill_to_full();
    test_random_traffic(300);

    send_idle_pct = 83;
    recv_idle_pct = 8;
    test_random_traffic(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(350);
    test_output_backpressure();

    wait_for_drain();
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("PASS sorted_set_table_core");
    end else begin
      $display("FAIL sorted_set_table_core");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/sst_pkg.sv
src/sst_cell.sv
src/sst_reduce.sv
src/sorted_set_table_core.sv
src/sst_checker.sv
sim/tb_sorted_set_table_core.sv
